// ----- src/ott_pkg.sv -----
// -----------------------------------------------------------------------------
// ott_pkg
// Types and constants shared by the owner tagged resource table.
// -----------------------------------------------------------------------------
`default_nettype none

package ott_pkg;

   localparam int ITEM_W  = 16;
   localparam int KIND_W  = 3;
   localparam int OWNER_W = 8;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_CLEAR  = 2'd3
   } ott_op_type;

   typedef enum logic [1:0] {
      ADD_NONE    = 2'd0,
      ADD_STORED  = 2'd1,
      ADD_PRESENT = 2'd2,
      ADD_FULL    = 2'd3
   } ott_add_status_type;

   typedef struct packed {
      logic [ITEM_W-1:0]  item;
      logic [KIND_W-1:0]  kind;
      logic [OWNER_W-1:0] owner;
   } ott_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT,
      ST_RESP
   } ott_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic scan_rd;
      logic commit;
      logic load_rsp;
   } ott_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rd_last;
      logic rsp_free;
   } ott_sts_type;

endpackage

`default_nettype wire

// ----- src/ott_req_if.sv -----
// -----------------------------------------------------------------------------
// ott_req_if
// Request channel: operation, item, kind and owner with valid/ready.
// -----------------------------------------------------------------------------
`default_nettype none

interface ott_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  req_type;
   logic [ott_pkg::ITEM_W-1:0]  item_id;
   logic [ott_pkg::KIND_W-1:0]  resource_kind;
   logic [ott_pkg::OWNER_W-1:0] owner_id;

   modport source (output valid, req_type, item_id, resource_kind, owner_id,
                   input ready);
   modport sink   (input valid, req_type, item_id, resource_kind, owner_id,
                   output ready);
endinterface

`default_nettype wire

// ----- src/ott_rsp_if.sv -----
// -----------------------------------------------------------------------------
// ott_rsp_if
// Response channel: answer bit and add status with valid/ready.
// -----------------------------------------------------------------------------
`default_nettype none

interface ott_rsp_if;
   logic       valid;
   logic       ready;
   logic       answer;
   logic [1:0] add_status;

   modport source (output valid, answer, add_status, input ready);
   modport sink   (input valid, answer, add_status, output ready);
endinterface

`default_nettype wire

// ----- src/ott_ram.sv -----
// -----------------------------------------------------------------------------
// ott_ram
// Generic single write port, single read port RAM with registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module ott_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- src/ott_datapath.sv -----
// -----------------------------------------------------------------------------
// ott_datapath
// Entry RAM, valid flags, scan address, compare stage, result accumulators
// and the response register.
// -----------------------------------------------------------------------------
`default_nettype none

module ott_datapath #(
   parameter int TABLE_ENTRIES = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ott_pkg::ott_cmd_type        cmd,
   output ott_pkg::ott_sts_type             sts,
   input  wire logic [1:0]                  req_type,
   input  wire logic [ott_pkg::ITEM_W-1:0]  item_id,
   input  wire logic [ott_pkg::KIND_W-1:0]  resource_kind,
   input  wire logic [ott_pkg::OWNER_W-1:0] owner_id,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_answer,
   output logic [1:0]                       rsp_add_status
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam int ENTRY_W = $bits(ott_pkg::ott_entry_type);

   // latched request
   ott_pkg::ott_op_type          op_ff;
   ott_pkg::ott_entry_type       key_ff;

   // scan pipeline
   logic [IDX_W-1:0]             rd_addr_ff;
   logic [IDX_W-1:0]             cmp_idx_ff;
   logic                         cmp_valid_ff;
   logic                         cmp_used_ff;
   logic [ENTRY_W-1:0]           rd_data;
   ott_pkg::ott_entry_type       rd_entry;

   logic [TABLE_ENTRIES-1:0]     valid_ff;
   logic [TABLE_ENTRIES-1:0]     valid_in;

   // accumulators
   logic                         dup_ff;
   logic                         found_ff;
   logic                         others_ff;
   logic                         free_found_ff;
   logic [IDX_W-1:0]             free_idx_ff;
   logic                         hit_found_ff;
   logic [IDX_W-1:0]             hit_idx_ff;

   logic                         key_match;
   logic                         owner_match;
   logic                         kind_nonzero;
   logic                         ram_we;

   // response
   logic                         rsp_valid_ff;
   logic                         answer_ff;
   ott_pkg::ott_add_status_type  add_status_ff;
   logic                         answer_in;
   ott_pkg::ott_add_status_type  add_status_in;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff       <= ott_pkg::ott_op_type'(req_type);
         key_ff.item  <= item_id;
         key_ff.kind  <= resource_kind;
         key_ff.owner <= owner_id;
      end
   end

   assign kind_nonzero = (key_ff.kind != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_addr_ff   <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.scan_rd;
         if (cmd.load_req) begin
            rd_addr_ff <= '0;
         end else if (cmd.scan_rd) begin
            rd_addr_ff <= rd_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         cmp_idx_ff  <= rd_addr_ff;
         cmp_used_ff <= valid_ff[rd_addr_ff];
      end
   end

   assign sts.rd_last = cmd.scan_rd && (rd_addr_ff == LAST_IDX);

   assign ram_we = cmd.commit && (op_ff == ott_pkg::OP_ADD) && kind_nonzero
                   && !dup_ff && free_found_ff;

   ott_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES),
      .AW    (IDX_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (free_idx_ff),
      .wdata (key_ff),
      .re    (cmd.scan_rd),
      .raddr (rd_addr_ff),
      .rdata (rd_data)
   );

   assign rd_entry    = ott_pkg::ott_entry_type'(rd_data);
   assign key_match   = cmp_used_ff && (rd_entry.item == key_ff.item)
                        && (rd_entry.kind == key_ff.kind);
   assign owner_match = (rd_entry.owner == key_ff.owner);

   // ascending scan, so the last free or own entry seen is the highest one
   always_ff @(posedge clock) begin
      if (reset || cmd.load_req) begin
         dup_ff        <= 1'b0;
         found_ff      <= 1'b0;
         others_ff     <= 1'b0;
         free_found_ff <= 1'b0;
         free_idx_ff   <= '0;
         hit_found_ff  <= 1'b0;
         hit_idx_ff    <= '0;
      end else if (cmp_valid_ff) begin
         if (!cmp_used_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= cmp_idx_ff;
         end
         if (key_match) begin
            found_ff <= 1'b1;
            if (owner_match) begin
               dup_ff       <= 1'b1;
               hit_found_ff <= 1'b1;
               hit_idx_ff   <= cmp_idx_ff;
            end else begin
               others_ff <= 1'b1;
            end
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit) begin
         case (op_ff)
            ott_pkg::OP_CLEAR: valid_in = '0;
            ott_pkg::OP_ADD: begin
               if (ram_we) begin
                  valid_in[free_idx_ff] = 1'b1;
               end
            end
            ott_pkg::OP_REMOVE: begin
               if (hit_found_ff) begin
                  valid_in[hit_idx_ff] = 1'b0;
               end
            end
            default: valid_in = valid_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      answer_in     = 1'b0;
      add_status_in = ott_pkg::ADD_NONE;
      case (op_ff)
         ott_pkg::OP_REMOVE: answer_in = !others_ff;
         ott_pkg::OP_QUERY:  answer_in = found_ff;
         ott_pkg::OP_ADD: begin
            if (!kind_nonzero) begin
               add_status_in = ott_pkg::ADD_NONE;
            end else if (dup_ff) begin
               add_status_in = ott_pkg::ADD_PRESENT;
            end else if (free_found_ff) begin
               add_status_in = ott_pkg::ADD_STORED;
            end else begin
               add_status_in = ott_pkg::ADD_FULL;
            end
         end
         default: answer_in = 1'b0;
      endcase
   end

   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         answer_ff     <= answer_in;
         add_status_ff <= add_status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_answer     = answer_ff;
   assign rsp_add_status = add_status_ff;

   // a store never lands on an entry in use
   a_store_into_free: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !valid_ff[free_idx_ff])
      else $error("add writes an occupied entry");

   // a remove with an own entry leaves that entry empty
   a_remove_frees: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (op_ff == ott_pkg::OP_REMOVE) && hit_found_ff)
      |=> !valid_ff[$past(hit_idx_ff)])
      else $error("removed entry still marked in use");

endmodule

`default_nettype wire

// ----- src/ott_ctrl.sv -----
// -----------------------------------------------------------------------------
// ott_ctrl
// Sequencer for one request: accept, scan the table, update, respond.
// -----------------------------------------------------------------------------
`default_nettype none

module ott_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output ott_pkg::ott_cmd_type      cmd,
   input  wire ott_pkg::ott_sts_type sts
);

   ott_pkg::ott_state_type state_ff;
   ott_pkg::ott_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ott_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ott_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ott_pkg::ST_SCAN;
            end
         end
         ott_pkg::ST_SCAN: begin
            if (sts.rd_last) begin
               state_in = ott_pkg::ST_DRAIN;
            end
         end
         ott_pkg::ST_DRAIN:  state_in = ott_pkg::ST_COMMIT;
         ott_pkg::ST_COMMIT: state_in = ott_pkg::ST_RESP;
         ott_pkg::ST_RESP: begin
            if (sts.rsp_free) begin
               state_in = ott_pkg::ST_IDLE;
            end
         end
         default: state_in = ott_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ott_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ott_pkg::ST_SCAN:   cmd.scan_rd  = 1'b1;
         ott_pkg::ST_DRAIN:  cmd          = '0;
         ott_pkg::ST_COMMIT: cmd.commit   = 1'b1;
         ott_pkg::ST_RESP:   cmd.load_rsp = sts.rsp_free;
         default:            cmd          = '0;
      endcase
   end

   // the response register is only loaded once the previous transfer left
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> sts.rsp_free)
      else $error("response loaded over a pending transfer");

endmodule

`default_nettype wire

// ----- src/owner_tagged_resource_table.sv -----
// -----------------------------------------------------------------------------
// owner_tagged_resource_table
// Table of (item, kind, owner) entries with add, remove, query and clear.
// -----------------------------------------------------------------------------
// Every request is served by a scan that reads the entry RAM one entry per
// cycle, then a drain, a commit and the loading of the response register;
// one request is in flight at a time, and a finished response waits in an
// output register while the next request is accepted. Occupancy lives in
// one flag per entry, all cleared together at reset and by clear, so there
// is no clearing pass. Add takes the highest free slot, remove frees the
// highest own matching slot, and kind zero never matches.
// -----------------------------------------------------------------------------
`default_nettype none

module owner_tagged_resource_table #(
   parameter int TABLE_ENTRIES = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ott_req_if.sink    req_chan,
   ott_rsp_if.source  rsp_chan
);

   ott_pkg::ott_cmd_type cmd;
   ott_pkg::ott_sts_type sts;

   ott_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ott_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_type       (req_chan.req_type),
      .item_id        (req_chan.item_id),
      .resource_kind  (req_chan.resource_kind),
      .owner_id       (req_chan.owner_id),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_answer     (rsp_chan.answer),
      .rsp_add_status (rsp_chan.add_status)
   );

endmodule

`default_nettype wire

// ----- bench/ott_table_checker.sv -----
// -----------------------------------------------------------------------------
// ott_table_checker
// Watches the request and response channels of the resource table, keeps a
// mirror of the table, works out the answer to every accepted request and
// compares each response transfer with the oldest answer still waiting.
// -----------------------------------------------------------------------------
`default_nettype none

module ott_table_checker #(
   parameter int ENTRIES = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   ott_req_if        req_mon,
   ott_rsp_if        rsp_mon,
   output int        error_count,
   output int        open_count
);

   typedef struct packed {
      logic                        answer;
      ott_pkg::ott_add_status_type status;
   } table_result_type;

   ott_pkg::ott_entry_type slot_mirror [ENTRIES];
   table_result_type       answer_q [$];
   int                     mismatches = 0;

   task automatic apply_request(input ott_pkg::ott_op_type op,
                                input logic [ott_pkg::ITEM_W-1:0] item,
                                input logic [ott_pkg::KIND_W-1:0] kind,
                                input logic [ott_pkg::OWNER_W-1:0] owner,
                                output table_result_type res);
      int   free_slot;
      int   own_slot;
      logic dup;
      logic foreign;
      free_slot  = -1;
      own_slot   = -1;
      dup        = 1'b0;
      foreign    = 1'b0;
      res.answer = 1'b0;
      res.status = ott_pkg::ADD_NONE;
      case (op)
         ott_pkg::OP_CLEAR: begin
            foreach (slot_mirror[i]) slot_mirror[i] = '0;
         end
         ott_pkg::OP_ADD: begin
            if (kind != '0) begin
               foreach (slot_mirror[i]) begin
                  if (slot_mirror[i].kind == '0)
                     free_slot = i;
                  else if (slot_mirror[i] == {item, kind, owner})
                     dup = 1'b1;
               end
               if (dup) begin
                  res.status = ott_pkg::ADD_PRESENT;
               end else if (free_slot >= 0) begin
                  slot_mirror[free_slot] = {item, kind, owner};
                  res.status = ott_pkg::ADD_STORED;
               end else begin
                  res.status = ott_pkg::ADD_FULL;
               end
            end
         end
         ott_pkg::OP_REMOVE: begin
            if (kind != '0) begin
               foreach (slot_mirror[i]) begin
                  if (slot_mirror[i].kind == kind && slot_mirror[i].item == item) begin
                     if (slot_mirror[i].owner == owner) own_slot = i;
                     else foreign = 1'b1;
                  end
               end
               // sharing is judged before the own entry goes away
               if (own_slot >= 0) slot_mirror[own_slot] = '0;
            end
            res.answer = !foreign;
         end
         default: begin
            if (kind != '0) begin
               foreach (slot_mirror[i])
                  if (slot_mirror[i].kind == kind && slot_mirror[i].item == item)
                     res.answer = 1'b1;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      table_result_type want;
      if (reset) begin
         foreach (slot_mirror[i]) slot_mirror[i] = '0;
         answer_q.delete();
      end else begin
         // the response leaving at this edge belongs to an earlier request
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (answer_q.size() == 0) begin
               $display("%0t: response with none expected: answer %0b add_status %0d",
                        $time, rsp_mon.answer, rsp_mon.add_status);
               mismatches++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_mon.answer !== want.answer) begin
                  $display("%0t: answer mismatch: expected %0b actual %0b",
                           $time, want.answer, rsp_mon.answer);
                  mismatches++;
               end
               if (rsp_mon.add_status !== want.status) begin
                  $display("%0t: add_status mismatch: expected %0d actual %0d",
                           $time, want.status, rsp_mon.add_status);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            apply_request(ott_pkg::ott_op_type'(req_mon.req_type), req_mon.item_id,
                          req_mon.resource_kind, req_mon.owner_id, want);
            answer_q.push_back(want);
         end
      end
      error_count <= mismatches;
      open_count  <= answer_q.size();
   end

endmodule

`default_nettype wire

// ----- bench/owner_tagged_resource_table_test.sv -----
// -----------------------------------------------------------------------------
// owner_tagged_resource_table_test
// Drives directed and random add, remove, query and clear requests into the
// resource table with random idling on both channels, and reports the
// verdict from the failure and open counts of the checker that sits beside it.
// -----------------------------------------------------------------------------
`default_nettype none

module owner_tagged_resource_table_test;

   localparam int ENTRIES     = 64;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = ENTRIES + 40;
   localparam int SEGMENTS    = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count;
   int   open_count;
   int   cycle_count = 0;
   bit   calm_phase = 1'b0;

   logic [ott_pkg::ITEM_W-1:0]  item_pool  [8];
   logic [ott_pkg::OWNER_W-1:0] owner_pool [4];

   ott_req_if req_if ();
   ott_rsp_if rsp_if ();

   owner_tagged_resource_table #(
      .TABLE_ENTRIES (ENTRIES)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   ott_table_checker #(
      .ENTRIES (ENTRIES)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .error_count (error_count),
      .open_count  (open_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** owner_tagged_resource_table: FAILED **");
         $finish;
      end
   end

   // response side: random stalls, sometimes long ones
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (calm_phase || $urandom_range(0, 99) >= 35) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b0;
            stall = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : 0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   task automatic send_req(input ott_pkg::ott_op_type op,
                           input logic [ott_pkg::ITEM_W-1:0] item,
                           input logic [ott_pkg::KIND_W-1:0] kind,
                           input logic [ott_pkg::OWNER_W-1:0] owner);
      int gap;
      gap = 0;
      if (!calm_phase && $urandom_range(0, 99) < 35)
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 4);
      repeat (gap) begin
         req_if.valid   <= 1'b0;
         req_if.item_id <= 16'($urandom_range(0, 16'hFFFF));
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.req_type      <= op;
      req_if.item_id       <= item;
      req_if.resource_kind <= kind;
      req_if.owner_id      <= owner;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // sender holds off until every outstanding response has come back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   task automatic send_random(input bit fill_mode);
      ott_pkg::ott_op_type         op;
      logic [ott_pkg::ITEM_W-1:0]  item;
      logic [ott_pkg::KIND_W-1:0]  kind;
      logic [ott_pkg::OWNER_W-1:0] owner;
      int                          roll;
      roll = $urandom_range(0, 99);
      if (fill_mode) begin
         if (roll < 85)      op = ott_pkg::OP_ADD;
         else if (roll < 93) op = ott_pkg::OP_REMOVE;
         else                op = ott_pkg::OP_QUERY;
      end else begin
         if (roll < 35)      op = ott_pkg::OP_ADD;
         else if (roll < 70) op = ott_pkg::OP_REMOVE;
         else if (roll < 95) op = ott_pkg::OP_QUERY;
         else                op = ott_pkg::OP_CLEAR;
      end
      if ($urandom_range(0, 3) == 0) item = 16'($urandom_range(0, 16'hFFFF));
      else                           item = item_pool[3'($urandom_range(0, 7))];
      if ($urandom_range(0, 15) == 0) kind = '0;
      else                            kind = 3'($urandom_range(1, 7));
      if ($urandom_range(0, 4) == 0) owner = 8'($urandom_range(0, 255));
      else                           owner = owner_pool[2'($urandom_range(0, 3))];
      send_req(op, item, kind, owner);
   endtask

   initial begin
      int seg_len;
      req_if.valid         <= 1'b0;
      req_if.req_type      <= ott_pkg::OP_ADD;
      req_if.item_id       <= '0;
      req_if.resource_kind <= '0;
      req_if.owner_id      <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: key extremes, shared and unshared removes, kind zero
      send_req(ott_pkg::OP_QUERY,  16'hFFFF, 3'd7, 8'h00);
      send_req(ott_pkg::OP_ADD,    16'hFFFF, 3'd7, 8'hFF);
      send_req(ott_pkg::OP_ADD,    16'hFFFF, 3'd7, 8'hFF);
      send_req(ott_pkg::OP_ADD,    16'hFFFF, 3'd7, 8'h00);
      send_req(ott_pkg::OP_QUERY,  16'hFFFF, 3'd7, 8'h33);
      send_req(ott_pkg::OP_REMOVE, 16'hFFFF, 3'd7, 8'hFF);
      send_req(ott_pkg::OP_REMOVE, 16'hFFFF, 3'd7, 8'hFF);
      send_req(ott_pkg::OP_REMOVE, 16'hFFFF, 3'd7, 8'h00);
      send_req(ott_pkg::OP_QUERY,  16'hFFFF, 3'd7, 8'h00);
      send_req(ott_pkg::OP_ADD,    16'h0000, 3'd1, 8'h00);
      send_req(ott_pkg::OP_ADD,    16'h0000, 3'd0, 8'h00);
      send_req(ott_pkg::OP_REMOVE, 16'h0000, 3'd0, 8'h00);
      send_req(ott_pkg::OP_QUERY,  16'h0000, 3'd0, 8'h00);
      send_req(ott_pkg::OP_QUERY,  16'h0000, 3'd1, 8'h5A);
      send_req(ott_pkg::OP_ADD,    16'h0000, 3'd2, 8'h00);
      send_req(ott_pkg::OP_ADD,    16'h0000, 3'd1, 8'h80);
      send_req(ott_pkg::OP_REMOVE, 16'h0000, 3'd1, 8'h00);
      send_req(ott_pkg::OP_REMOVE, 16'h0000, 3'd1, 8'h00);
      send_req(ott_pkg::OP_CLEAR,  16'hA5C3, 3'd5, 8'h96);
      send_req(ott_pkg::OP_QUERY,  16'h0000, 3'd1, 8'h00);
      send_req(ott_pkg::OP_REMOVE, 16'h0000, 3'd1, 8'h80);
      wait_drained();

      // random: fill phases push the table to full, mixed phases churn it
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         item_pool[0] = 16'h0000;
         item_pool[1] = 16'hFFFF;
         for (int k = 2; k < 8; k++) item_pool[k] = 16'($urandom_range(0, 16'hFFFF));
         owner_pool[0] = 8'h00;
         owner_pool[1] = 8'hFF;
         owner_pool[2] = 8'($urandom_range(0, 255));
         owner_pool[3] = 8'($urandom_range(0, 255));
         calm_phase = (seg == 4);
         seg_len = (seg % 3 == 1) ? 90 : 45;
         repeat (seg_len) send_random(seg % 3 == 1);
         if (seg == 5 || seg == 8) wait_drained();
      end
      calm_phase = 1'b0;

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0 && open_count == 0)
         $display("** owner_tagged_resource_table: PASSED **");
      else
         $display("** owner_tagged_resource_table: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
